/* rtl/core/smps_pkg.sv */
package smps_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] mid_value;
        logic                      is_last;
        logic                      overflow;
    } out_item_t;

endpackage

/* rtl/core/smps_stream_if.sv */
interface smps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/smps_store.sv */
module smps_store #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [smps_pkg::VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [smps_pkg::VALUE_W-1:0] rd_data
);
    import smps_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/smps_ctrl.sv */
module smps_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    smps_stream_if.sink                         items,
    smps_stream_if.source                       results,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output logic signed [smps_pkg::VALUE_W-1:0] wr_data,
    output logic [AW-1:0]                       rd_addr,
    input  logic signed [smps_pkg::VALUE_W-1:0] rd_data
);
    import smps_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    typedef enum logic [2:0] {
        S_LOAD,
        S_CAND,
        S_CWAIT,
        S_SCAN,
        S_FIRST,
        S_DRAIN
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic                      dropped_reg;
    logic [CW-1:0]             n_reg;
    logic [CW-1:0]             i_reg;
    logic [CW-1:0]             j_reg;
    logic [CW-1:0]             rank_reg;
    logic signed [VALUE_W-1:0] cand_reg;
    logic signed [VALUE_W-1:0] lo_reg;
    logic signed [VALUE_W-1:0] hi_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_is_last_reg;
    logic                      out_overflow_reg;

    logic                      has_space;
    logic                      precedes;
    logic [CW-1:0]             rank_next;
    logic [CW-1:0]             mid;
    logic                      scan_last;
    logic                      cand_last;
    logic [CW-1:0]             i_next;
    logic [CW-1:0]             j_next;

    // An element ranks below the candidate if it is smaller, or equal and stored earlier,
    // so every stored element gets a distinct position in ascending order.
    assign has_space = count_reg < DEPTH_C;
    assign precedes  = (rd_data < cand_reg) || ((rd_data == cand_reg) && (j_reg < i_reg));
    assign rank_next = rank_reg + CW'(precedes);
    assign mid       = n_reg >> 1;
    assign scan_last = j_reg == (n_reg - ONE_C);
    assign cand_last = i_reg == (n_reg - ONE_C);
    assign i_next    = i_reg + ONE_C;
    assign j_next    = j_reg + ONE_C;

    assign items.ready = (state_reg == S_LOAD);
    assign wr_en       = items.valid && (state_reg == S_LOAD) && has_space;
    assign wr_addr     = count_reg[AW-1:0];
    assign wr_data     = items.payload.value;

    always_comb
    begin
        case (state_reg)
            S_CAND:  rd_addr = i_reg[AW-1:0];
            S_CWAIT: rd_addr = '0;
            S_SCAN:  rd_addr = scan_last ? i_next[AW-1:0] : j_next[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = '{mid_value: out_value_reg,
                               is_last:   out_is_last_reg,
                               overflow:  out_overflow_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (items.valid)
                    begin
                        if (has_space)
                        begin
                            count_reg <= count_reg + ONE_C;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (items.payload.last)
                        begin
                            n_reg     <= has_space ? count_reg + ONE_C : count_reg;
                            i_reg     <= '0;
                            state_reg <= S_CAND;
                        end
                    end
                end
                S_CAND:
                begin
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    cand_reg  <= rd_data;
                    j_reg     <= '0;
                    rank_reg  <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    j_reg    <= j_next;
                    rank_reg <= rank_next;
                    if (scan_last)
                    begin
                        if ((mid != '0) && (rank_next == mid - ONE_C))
                        begin
                            lo_reg <= cand_reg;
                        end
                        if (rank_next == mid)
                        begin
                            hi_reg <= cand_reg;
                        end
                        i_reg     <= i_next;
                        state_reg <= cand_last ? S_FIRST : S_CWAIT;
                    end
                end
                S_FIRST:
                begin
                    out_valid_reg    <= 1'b1;
                    out_value_reg    <= (n_reg >= TWO_C) ? lo_reg : hi_reg;
                    out_is_last_reg  <= (n_reg < TWO_C);
                    out_overflow_reg <= dropped_reg;
                    state_reg        <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (results.ready)
                    begin
                        if (out_is_last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            count_reg     <= '0;
                            dropped_reg   <= 1'b0;
                            state_reg     <= S_LOAD;
                        end
                        else
                        begin
                            out_value_reg   <= hi_reg;
                            out_is_last_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sorted_middle_pair_select_unit.sv */
// Channel   Direction  Payload                          Transfer
// items     in         value (s32), last                valid && ready
// results   out        mid_value (s32), is_last, overflow  valid && ready
//
// Each value is written to the element memory while the set loads, up to DEPTH values.
// After the last value, each of the n stored values is ranked against all others by
// scanning the single memory read port.
// The middle pair (one value if n is 1) is then offered on results, one transfer each.
// Reset clears the element count and the overflow flag; memory contents are not cleared.
// Items are stalled from the last value of a set until its final result is taken.
module sorted_middle_pair_select_unit #(
    parameter int DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    smps_stream_if.sink   items,
    smps_stream_if.source results
);
    import smps_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    smps_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smps_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* rtl/core/smps_checker.sv */
module smps_checker (
    input logic clk,
    input logic rst_n,
    input logic items_valid,
    input logic items_ready,
    input logic items_last,
    input logic results_valid,
    input logic results_ready,
    input logic results_is_last
);

    // The unit never takes new values while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(items_ready && results_valid))
        else $error("items ready while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (items_valid && items_ready && items_last) |=> !items_ready)
        else $error("items still ready after the last value of a set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results_valid && results_ready && !results_is_last) |=> results_valid)
        else $error("second result of a set missing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results_valid && results_ready && results_is_last) |=> !results_valid)
        else $error("result offered after the final result of a set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results_valid && !results_ready) |=> results_valid)
        else $error("result withdrawn before transfer");

endmodule

bind sorted_middle_pair_select_unit smps_checker u_smps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .items_valid     (items.valid),
    .items_ready     (items.ready),
    .items_last      (items.payload.last),
    .results_valid   (results.valid),
    .results_ready   (results.ready),
    .results_is_last (results.payload.is_last)
);

/* bench/tb.sv */
module tb;
    import smps_pkg::*;

    localparam int DEPTH = 256;
    localparam int ITEMS = 1950;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int PAUSE_SET = 25;
    localparam int DIR_ROWS = 20;

    localparam logic signed [VALUE_W-1:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] MINV = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        bit                        typed;
        int                        n_res;
        out_item_t                 res0;
        out_item_t                 res1;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smps_stream_if #(.payload_t(in_item_t))  items_ch ();
    smps_stream_if #(.payload_t(out_item_t)) results_ch ();

    sorted_middle_pair_select_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .results(results_ch)
    );

    logic signed [VALUE_W-1:0] loaded_vals [DEPTH];
    int unsigned               loaded_count = 0;
    logic                      loaded_dropped = 1'b0;
    out_item_t                 expected_middles [$];
    int                        errors = 0;
    int                        sent = 0;
    int                        cycles = 0;
    bit                        snd_idle = 1'b1;

    // Rows with a typed result are read straight off the rules; the rest use the predictor.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{MAXV, 1'b1, 1'b1, 1, '{MAXV, 1'b1, 1'b0}, '0},
        '{MINV, 1'b1, 1'b1, 1, '{MINV, 1'b1, 1'b0}, '0},
        '{MINV, 1'b0, 1'b0, 0, '0, '0},
        '{MAXV, 1'b1, 1'b1, 2, '{MINV, 1'b0, 1'b0}, '{MAXV, 1'b1, 1'b0}},
        '{MAXV, 1'b0, 1'b0, 0, '0, '0},
        '{MINV, 1'b1, 1'b1, 2, '{MINV, 1'b0, 1'b0}, '{MAXV, 1'b1, 1'b0}},
        '{MAXV, 1'b0, 1'b0, 0, '0, '0},
        '{MAXV, 1'b1, 1'b1, 2, '{MAXV, 1'b0, 1'b0}, '{MAXV, 1'b1, 1'b0}},
        '{32'sd0, 1'b0, 1'b0, 0, '0, '0},
        '{-32'sd1, 1'b0, 1'b0, 0, '0, '0},
        '{32'sd1, 1'b1, 1'b0, 0, '0, '0},
        '{32'sd5, 1'b0, 1'b0, 0, '0, '0},
        '{32'sd5, 1'b0, 1'b0, 0, '0, '0},
        '{-32'sd5, 1'b0, 1'b0, 0, '0, '0},
        '{32'sd5, 1'b0, 1'b0, 0, '0, '0},
        '{-32'sd5, 1'b1, 1'b0, 0, '0, '0},
        '{32'sh5555_5555, 1'b0, 1'b0, 0, '0, '0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, 0, '0, '0},
        '{32'sd0, 1'b0, 1'b0, 0, '0, '0},
        '{-32'sd1, 1'b1, 1'b0, 0, '0, '0}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int predict_middle(input logic signed [VALUE_W-1:0] v, input logic lst,
                                          output out_item_t r0, output out_item_t r1);
        logic signed [VALUE_W-1:0] ranked [DEPTH];
        logic signed [VALUE_W-1:0] key;
        int n;
        int m;
        int j;
        int cnt;
        r0 = '0;
        r1 = '0;
        cnt = 0;
        if (loaded_count < DEPTH)
        begin
            loaded_vals[loaded_count] = v;
            loaded_count++;
        end
        else
        begin
            loaded_dropped = 1'b1;
        end
        if (!lst)
            return 0;
        n = loaded_count;
        for (int i = 0; i < n; i++)
            ranked[i] = loaded_vals[i];
        for (int i = 1; i < n; i++)
        begin
            key = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > key)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        m = n / 2;
        if (m >= 1)
        begin
            r0 = '{mid_value: ranked[m-1], is_last: 1'b0, overflow: loaded_dropped};
            r1 = '{mid_value: ranked[m], is_last: 1'b1, overflow: loaded_dropped};
            cnt = 2;
        end
        else
        begin
            r0 = '{mid_value: ranked[m], is_last: 1'b1, overflow: loaded_dropped};
            cnt = 1;
        end
        loaded_count = 0;
        loaded_dropped = 1'b0;
        return cnt;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value(input int mode);
        int pick;
        pick = $urandom_range(0, 5);
        case (mode)
            1: return VALUE_W'(int'($urandom_range(0, 8)) - 4);
            2:
            begin
                case (pick)
                    0: return MINV;
                    1: return MAXV;
                    2: return '0;
                    3: return '1;
                    4: return MINV + 1;
                    default: return MAXV - 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic feed(input logic signed [VALUE_W-1:0] v, input logic lst, input bit typed,
                        input int typed_n, input out_item_t t0, input out_item_t t1);
        int gap;
        int cnt;
        out_item_t p0;
        out_item_t p1;
        if (sent % 40 == 0)
            snd_idle = ($urandom_range(0, 2) != 0);
        gap = snd_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid <= 1'b1;
        items_ch.payload <= '{value: v, last: lst};
        do
            @(posedge clk);
        while (!items_ch.ready);
        sent++;
        cnt = predict_middle(v, lst, p0, p1);
        if (typed)
        begin
            cnt = typed_n;
            p0 = t0;
            p1 = t1;
        end
        if (cnt > 0)
            expected_middles.push_back(p0);
        if (cnt > 1)
            expected_middles.push_back(p1);
    endtask

    initial
    begin : result_sink
        int gap;
        int taken;
        bit rcv_idle;
        out_item_t got;
        out_item_t want;
        taken = 0;
        rcv_idle = 1'b1;
        results_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (taken % 20 == 0)
                rcv_idle = ($urandom_range(0, 2) != 0);
            gap = rcv_idle ? $urandom_range(0, 16) : 0;
            // A long hold-off lets items back up behind a finished sort.
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_ch.valid);
            got = results_ch.payload;
            taken++;
            if (expected_middles.size() == 0)
            begin
                $error("result transfer with nothing expected: mid_value %0d", got.mid_value);
                errors++;
            end
            else
            begin
                want = expected_middles.pop_front();
                if (got.mid_value !== want.mid_value)
                begin
                    $error("mid_value: expected %0d, actual %0d", want.mid_value, got.mid_value);
                    errors++;
                end
                if (got.is_last !== want.is_last)
                begin
                    $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                    errors++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin : item_source
        int set_idx;
        int sz;
        int mode;
        items_ch.valid <= 1'b0;
        items_ch.payload <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            feed(dir_tab[r].value, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].n_res,
                 dir_tab[r].res0, dir_tab[r].res1);

        for (set_idx = 0; sent < ITEMS; set_idx++)
        begin
            // The sender stops once until every expected transfer has come back.
            if (set_idx == PAUSE_SET)
            begin
                items_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_middles.size() != 0);
            end
            case (set_idx)
                8: sz = DEPTH;
                40: sz = DEPTH + 1;
                80: sz = DEPTH + 14;
                default: sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
            endcase
            mode = $urandom_range(0, 3);
            for (int k = 0; k < sz; k++)
                feed(draw_value(mode), k == sz - 1, 1'b0, 0, '0, '0);
        end
        items_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (expected_middles.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && expected_middles.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/smps_pkg.sv
rtl/core/smps_stream_if.sv
rtl/core/smps_store.sv
rtl/core/smps_ctrl.sv
rtl/core/sorted_middle_pair_select_unit.sv
rtl/core/smps_checker.sv
bench/tb.sv
